// ===== design/keyed_index_permutation_assert.svh =====
// ---------------------------------------------------------------------------
// keyed_index_permutation_assert.svh
// Assertion macros for the keyed index permutation block.
// ---------------------------------------------------------------------------
`ifndef KEYED_INDEX_PERMUTATION_ASSERT_SVH
`define KEYED_INDEX_PERMUTATION_ASSERT_SVH
`ifndef SYNTH
// checked outside reset
`define KIP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// checked at every edge, reset included
`define KIP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define KIP_ASSERT(label, prop, msg)
`define KIP_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

// ===== design/kip_pkg.sv =====
// ---------------------------------------------------------------------------
// kip_pkg
// Constants shared by the keyed index permutation block.
// ---------------------------------------------------------------------------
`default_nettype none

package kip_pkg;

  localparam int INDEX_W        = 31;
  localparam int DEF_INDEX_BITS = 31;

  // register indexes on the config port
  localparam logic [1:0] REG_ITEM_COUNT  = 2'd0;
  localparam logic [1:0] REG_PERM_KEY    = 2'd1;
  localparam logic [1:0] REG_ROUND_COUNT = 2'd2;

  localparam logic [31:0] RST_ITEM_COUNT  = 32'd1;
  localparam logic [31:0] RST_PERM_KEY    = 32'd0;
  localparam logic [3:0]  RST_ROUND_COUNT = 4'd3;

  // round function and key schedule constants
  localparam logic [31:0] HASH_MUL_A = 32'h7FEB352D;
  localparam logic [31:0] HASH_MUL_B = 32'h846CA68B;
  localparam logic [31:0] KEY_STEP   = 32'h9E3779B1;

endpackage

`default_nettype wire

// ===== design/keyed_index_permutation.sv =====
// done is raised in the cycle after accept for an out-of-range index or count of one.
// Otherwise S_SIZE runs once, then each pass (cycle walking, usually 1 or 2) runs
// S_SPLIT, then S_MUL1, S_MUL2 and S_MIX for each round (the two multiplies share
// one 32x32 multiplier), then S_JOIN. busy stays high until done, blocking start.
// done is a one-cycle strobe the receiver cannot stall.
// Reset (rst, synchronous): item_count = 1, perm_key = 0, round_count = 3, idle.
// ---------------------------------------------------------------------------
// keyed_index_permutation
// Keyed permutation of 0..n-1, n = item_count capped at 2^MAX_INDEX_BITS: an
// unbalanced Feistel network over the next power of two, redone until below n.
// ---------------------------------------------------------------------------
`default_nettype none

`include "keyed_index_permutation_assert.svh"

module keyed_index_permutation #(
  parameter int MAX_INDEX_BITS = kip_pkg::DEF_INDEX_BITS
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // config port
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [3:0]                  paddr,
  input  wire logic [31:0]                 pwdata,
  output logic      [31:0]                 prdata,
  output logic                             pready,
  // command
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [kip_pkg::INDEX_W-1:0] index_in,
  // result
  output logic                             done,
  output logic      [kip_pkg::INDEX_W-1:0] index_out,
  output logic                             range_error
);

  import kip_pkg::*;

  localparam int M  = MAX_INDEX_BITS;
  localparam int RW = $clog2(MAX_INDEX_BITS + 1);
  localparam logic [31:0] CAP = 32'(64'd1 << MAX_INDEX_BITS);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SIZE  = 3'd1;
  localparam logic [2:0] S_SPLIT = 3'd2;
  localparam logic [2:0] S_MUL1  = 3'd3;
  localparam logic [2:0] S_MUL2  = 3'd4;
  localparam logic [2:0] S_MIX   = 3'd5;
  localparam logic [2:0] S_JOIN  = 3'd6;

  function automatic logic [M-1:0] low_mask(input logic [RW-1:0] w);
    low_mask = {M{1'b1}} >> (RW'(M) - w);
  endfunction

  // config registers
  logic [31:0] item_count;
  logic [31:0] perm_key;
  logic [3:0]  round_count;

  logic cfg_wr;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_count  <= RST_ITEM_COUNT;
      perm_key    <= RST_PERM_KEY;
      round_count <= RST_ROUND_COUNT;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_ITEM_COUNT:  item_count  <= pwdata;
        REG_PERM_KEY:    perm_key    <= pwdata;
        REG_ROUND_COUNT: round_count <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_ITEM_COUNT:  prdata = item_count;
      REG_PERM_KEY:    prdata = perm_key;
      REG_ROUND_COUNT: prdata = {28'd0, round_count};
      default:         prdata = 32'd0;
    endcase
  end

  // datapath state
  logic [2:0]    state;
  logic [M-1:0]  nm1;       // effective count minus one
  logic [M-1:0]  yv;        // value entering the next pass
  logic [RW-1:0] r_bits;
  logic [RW-1:0] hi_w;
  logic [RW-1:0] lo_w;
  logic [M-1:0]  hi;
  logic [M-1:0]  lo;
  logic [3:0]    rnd;
  logic [31:0]   racc;      // rnd * KEY_STEP
  logic [31:0]   prod;

  logic        accept;
  logic [31:0] n_sat;
  logic        in_err;
  logic        n_one;
  assign accept = start && !busy;
  assign busy   = (state != S_IDLE);
  assign n_sat  = (item_count > CAP) ? CAP : item_count;
  assign in_err = ({1'b0, index_in} >= n_sat);
  assign n_one  = (n_sat == 32'd1);

  // bit length of nm1
  logic [RW-1:0] r_calc;
  always_comb begin
    r_calc = '0;
    for (int i = 0; i < M; i++) begin
      if (nm1[i]) r_calc = RW'(i + 1);
    end
  end

  // shared multiplier, low word only
  logic [31:0] h0;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [31:0] mul_lo;
  assign h0 = 32'(lo) + (perm_key ^ racc);
  always_comb begin
    if (state == S_MUL1) begin
      mul_a = h0 ^ (h0 >> 16);
      mul_b = HASH_MUL_A;
    end else begin
      mul_a = prod ^ (prod >> 15);
      mul_b = HASH_MUL_B;
    end
  end
  assign mul_lo = mul_a * mul_b;

  logic [31:0]   h_fin;
  logic [M-1:0]  f_val;
  logic [M-1:0]  hi_mask;
  logic [M-1:0]  y_join;
  logic [RW-1:0] split_hi_w;
  logic [RW-1:0] split_lo_w;
  logic          last_round;
  assign h_fin      = prod ^ (prod >> 16);
  assign hi_mask    = low_mask(hi_w);
  assign f_val      = h_fin[M-1:0] & hi_mask;
  assign y_join     = ((hi << lo_w) | lo) & low_mask(r_bits);
  assign split_hi_w = r_bits >> 1;
  assign split_lo_w = r_bits - split_hi_w;
  assign last_round = ((5'(rnd) + 5'd1) == 5'(round_count));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (in_err || n_one) begin
              done        <= 1'b1;
              index_out   <= '0;
              range_error <= in_err;
            end else begin
              yv    <= index_in[M-1:0];
              nm1   <= M'(n_sat - 32'd1);
              state <= S_SIZE;
            end
          end
        end
        S_SIZE: begin
          r_bits <= r_calc;
          state  <= S_SPLIT;
        end
        S_SPLIT: begin
          hi_w  <= split_hi_w;
          lo_w  <= split_lo_w;
          hi    <= (yv >> split_lo_w) & low_mask(split_hi_w);
          lo    <= yv & low_mask(split_lo_w);
          rnd   <= '0;
          racc  <= '0;
          state <= (round_count == 4'd0) ? S_JOIN : S_MUL1;
        end
        S_MUL1: begin
          prod  <= mul_lo;
          state <= S_MUL2;
        end
        S_MUL2: begin
          prod  <= mul_lo;
          state <= S_MIX;
        end
        S_MIX: begin
          // halves and their widths swap every round
          hi    <= lo;
          lo    <= (hi ^ f_val) & hi_mask;
          hi_w  <= lo_w;
          lo_w  <= hi_w;
          rnd   <= rnd + 4'd1;
          racc  <= racc + KEY_STEP;
          state <= last_round ? S_JOIN : S_MUL1;
        end
        S_JOIN: begin
          if (y_join > nm1) begin
            yv    <= y_join;      // walk again
            state <= S_SPLIT;
          end else begin
            done        <= 1'b1;
            index_out   <= INDEX_W'(y_join);
            range_error <= 1'b0;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `KIP_ASSERT(a_err_zero, done && range_error |-> index_out == '0, "error word with nonzero index")
  `KIP_ASSERT(a_done_src, done |-> ($past(accept) || $past(state == S_JOIN)), "unexpected done")
  `KIP_ASSERT(a_width_sum, (state == S_MUL1 || state == S_MUL2 || state == S_MIX) |-> (5'(hi_w) + 5'(lo_w)) == 5'(r_bits), "half widths lost sum")
  `KIP_ASSERT(a_rnd_bound, (state == S_MUL1 || state == S_MUL2 || state == S_MIX) |-> rnd < round_count, "round counter overrun")

endmodule

`default_nettype wire

// ===== tb/sv/keyed_index_permutation_tb.sv =====
// ---------------------------------------------------------------------------
// keyed_index_permutation_tb
// Self-checking bench for the keyed index permutation block. It sets the count,
// key and round registers over the config port while the block is idle, then
// issues index words in random bursts. Each accepted index is run through a
// local Feistel predictor, and every done strobe is checked in order against
// those predictions.
// ---------------------------------------------------------------------------
module keyed_index_permutation_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import kip_pkg::*;

  typedef struct packed {
    logic [INDEX_W-1:0] index;
    logic               err;
  } perm_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [3:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               start = 1'b0;
  logic               busy;
  logic [INDEX_W-1:0] index_in = '0;
  logic               done;
  logic [INDEX_W-1:0] index_out;
  logic               range_error;

  // local copy of the config registers
  logic [31:0] cfg_count = RST_ITEM_COUNT;
  logic [31:0] cfg_key = RST_PERM_KEY;
  logic [3:0]  cfg_rounds = RST_ROUND_COUNT;

  logic [INDEX_W-1:0] index_backlog[$];
  perm_result_t       permuted_due[$];
  int                 error_count = 0;

  keyed_index_permutation i_dut (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .start      (start),
    .busy       (busy),
    .index_in   (index_in),
    .done       (done),
    .index_out  (index_out),
    .range_error(range_error)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [31:0] round_hash(logic [31:0] v, logic [31:0] k);
    logic [31:0] h;
    h = v + k;
    h ^= h >> 16;
    h = h * HASH_MUL_A;
    h ^= h >> 15;
    h = h * HASH_MUL_B;
    h ^= h >> 16;
    return h;
  endfunction

  function automatic logic [31:0] width_mask(int n);
    logic [63:0] m;
    m = (64'd1 << n) - 64'd1;
    return m[31:0];
  endfunction

  // capped count actually used by the block
  function automatic longint unsigned active_count();
    longint unsigned n;
    n = cfg_count;
    if (n > 64'h8000_0000) n = 64'h8000_0000;
    return n;
  endfunction

  // one pass of the unbalanced network over r bits; halves swap widths each round
  function automatic logic [31:0] feistel_pass(logic [31:0] v, int r);
    int          hi_w, lo_w, tw;
    logic [31:0] hi_m, lo_m, tm, hi, lo, f, nlo, rkey, rnd;
    hi_w = r / 2;
    lo_w = r - hi_w;
    hi_m = width_mask(hi_w);
    lo_m = width_mask(lo_w);
    hi = (v >> lo_w) & hi_m;
    lo = v & lo_m;
    rnd = '0;
    while (rnd < cfg_rounds) begin
      rkey = cfg_key ^ (rnd * KEY_STEP);
      f = round_hash(lo, rkey) & hi_m;
      nlo = (hi ^ f) & hi_m;
      hi = lo;
      lo = nlo;
      tw = hi_w; hi_w = lo_w; lo_w = tw;
      tm = hi_m; hi_m = lo_m; lo_m = tm;
      rnd++;
    end
    return ((hi << lo_w) | lo) & width_mask(r);
  endfunction

  function automatic perm_result_t permute_index(logic [INDEX_W-1:0] idx);
    perm_result_t    res;
    longint unsigned n;
    int              r;
    logic [31:0]     y;
    n = active_count();
    res.index = '0;
    res.err = 1'b0;
    if (idx >= n) begin
      res.err = 1'b1;
      return res;
    end
    if (n == 1) return res;
    r = 0;
    while ((64'd1 << r) < n) r++;
    y = 32'(idx);
    // cycle walking: repeat the network until the value lands inside the range
    do y = feistel_pass(y, r); while (y >= n);
    res.index = y[INDEX_W-1:0];
    return res;
  endfunction

  // driver: bursts of back-to-back words with random gaps between them
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (start && !busy) permuted_due.push_back(permute_index(index_in));
      if (start && busy) begin
        // hold the word until the block takes it
      end else if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (index_backlog.size() != 0) begin
        start <= 1'b1;
        index_in <= index_backlog.pop_front();
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 16);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: done is a single-cycle strobe, checked against the oldest prediction
  always @(posedge clk) begin
    perm_result_t want;
    if (!rst && done) begin
      if (permuted_due.size() == 0) begin
        if (error_count < 10)
          $display("%0t: unexpected result index_out=%0d range_error=%0b",
                   $time, index_out, range_error);
        error_count++;
      end else begin
        want = permuted_due.pop_front();
        if (index_out !== want.index || range_error !== want.err) begin
          if (error_count < 10)
            $display("%0t: mismatch expected index_out=%0d range_error=%0b, got %0d %0b",
                     $time, want.index, want.err, index_out, range_error);
          error_count++;
        end
      end
    end
  end

  task automatic reg_write(logic [1:0] reg_idx, logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (reg_idx)
      REG_ITEM_COUNT:  cfg_count = value;
      REG_PERM_KEY:    cfg_key = value;
      REG_ROUND_COUNT: cfg_rounds = value[3:0];
      default: ;
    endcase
  endtask

  task automatic set_config(logic [31:0] count, logic [31:0] key, logic [3:0] rounds);
    logic [31:0] junk;
    junk = $urandom;
    reg_write(REG_ITEM_COUNT, count);
    reg_write(REG_PERM_KEY, key);
    // upper bits of the round register are don't-care
    reg_write(REG_ROUND_COUNT, {junk[31:4], rounds});
  endtask

  // sampled mid-cycle so the driver's edge updates are already visible
  task automatic wait_idle();
    do @(negedge clk);
    while (index_backlog.size() != 0 || start || busy || permuted_due.size() != 0);
  endtask

  function automatic logic [31:0] pick_count();
    int sel;
    int b;
    sel = $urandom_range(0, 9);
    b = $urandom_range(1, 30);
    case (sel)
      0, 1, 2, 3: return $urandom_range(2, 300);
      4, 5:       return $urandom_range(301, 1 << 20);
      6:          return $urandom;
      7:          return (32'd1 << b) + $urandom_range(0, 1);
      8: begin
        case ($urandom_range(0, 5))
          0:       return 32'd0;
          1:       return 32'd1;
          2:       return 32'd2;
          3:       return 32'h8000_0000;
          4:       return 32'h8000_0001;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      default:    return $urandom_range(32'h7FFF_FFFF, 1 << 20);
    endcase
  endfunction

  function automatic logic [INDEX_W-1:0] pick_index();
    longint unsigned n;
    longint unsigned v;
    int              sel;
    n = active_count();
    sel = $urandom_range(0, 19);
    if (n == 0 || sel < 3) v = $urandom;
    else if (sel < 5) v = n - 1 + $urandom_range(0, 2);
    else v = {$urandom, $urandom} % n;
    return v[INDEX_W-1:0];
  endfunction

  initial begin
    logic [31:0] key;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // reset values: count of one, so only index 0 is in range
    index_backlog = '{31'd0, 31'd1, 31'h7FFF_FFFF};
    wait_idle();

    // empty range: everything flagged
    reg_write(REG_ITEM_COUNT, 32'd0);
    index_backlog = '{31'd0, 31'd5};
    wait_idle();

    // count saturates at 2^31, max rounds, all-ones key
    set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd15);
    index_backlog = '{31'd0, 31'h7FFF_FFFF, 31'h2AAA_AAAA, 31'h5555_5555};
    wait_idle();

    // zero rounds is the identity
    set_config(32'd1000, $urandom, 4'd0);
    index_backlog = '{31'd999, 31'd1000, 31'd5};
    wait_idle();

    set_config(32'h8000_0000, 32'd0, 4'd1);
    index_backlog = '{31'h7FFF_FFFF, 31'd0};
    wait_idle();

    set_config(32'd2, 32'h1234_5678, 4'd3);
    index_backlog = '{31'd0, 31'd1, 31'd2};
    wait_idle();

    // just above a power of two: lots of cycle walking
    set_config(32'd3, $urandom, 4'd15);
    index_backlog = '{31'd0, 31'd1, 31'd2, 31'd3};
    wait_idle();

    for (int ph = 0; ph < 12; ph++) begin
      case ($urandom_range(0, 5))
        0:       key = 32'd0;
        1:       key = 32'hFFFF_FFFF;
        default: key = $urandom;
      endcase
      set_config((ph == 11) ? 32'h8000_0000 : pick_count(), key,
                 4'($urandom_range(0, 15)));
      for (int i = 0; i < 58; i++) index_backlog.push_back(pick_index());
      wait_idle();
    end

    // catch any stray strobe
    repeat (100) @(posedge clk);
    if (error_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  initial begin
    #10ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+design
design/kip_pkg.sv
design/keyed_index_permutation.sv
tb/sv/keyed_index_permutation_tb.sv
